// ===== hdl/wbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wbc_pkg;

    localparam logic [29:0] MOD_ONE    = 30'd1000000007;
    localparam logic [29:0] MOD_TWO    = 30'd1000000009;
    localparam logic [19:0] BASE_RESET = 20'd131;
    localparam logic        OP_WORD    = 1'b0;
    localparam logic        OP_TEXT    = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [4:0] letter;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [29:0] ways;
        logic        overflow;
    } result_t;

    // operand selection for the modular multipliers
    typedef enum logic [1:0] {
        MSEL_WORD   = 2'd0,
        MSEL_PREFIX = 2'd1,
        MSEL_POWER  = 2'd2,
        MSEL_CHECK  = 2'd3
    } msel_t;

    typedef struct packed {
        logic  accept;
        logic  mul_start;
        msel_t msel;
        logic  word_upd;
        logic  word_clr;
        logic  w_clr;
        logic  w_inc;
        logic  dict_rd;
        logic  dict_wr;
        logic  set_ovf;
        logic  pref_latch;
        logic  text_store;
        logic  split_init;
        logic  row_rd;
        logic  row_ld;
        logic  split_wr;
        logic  i_dec;
        logic  ent_ld;
        logic  chk_done;
        logic  finish;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic is_text;
        logic is_last;
        logic text_full;
        logic word_long;
        logic w_end;
        logic dict_hit;
        logic dict_full;
        logic n_zero;
        logic i_zero;
        logic ent_skip;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/wbc_mulmod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Serial modular multiply: one multiplier bit per cycle, MSB first.
module wbc_mulmod (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [29:0] a,
    input  wire logic [29:0] b,
    input  wire logic [29:0] modulus,
    output logic             done,
    output logic [29:0]      product
);

    logic        run_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [29:0] r_reg;
    logic [29:0] a_reg;
    logic [29:0] b_reg;
    logic [29:0] r_next;
    logic [30:0] t_dbl;
    logic [30:0] t_red;
    logic [30:0] t_add;
    logic [30:0] t_fin;

    always_comb
    begin
        t_dbl  = {r_reg, 1'b0};
        t_red  = (t_dbl >= {1'b0, modulus}) ? t_dbl - {1'b0, modulus} : t_dbl;
        t_add  = t_red + (b_reg[29] ? {1'b0, a_reg} : 31'd0);
        t_fin  = (t_add >= {1'b0, modulus}) ? t_add - {1'b0, modulus} : t_add;
        r_next = t_fin[29:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 5'd29;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= 30'd0;
            a_reg <= a;
            b_reg <= b;
        end
        else if (run_reg)
        begin
            r_reg <= r_next;
            b_reg <= {b_reg[28:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = r_reg;

    a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (r_reg < modulus))
        else $error("running remainder reached the modulus");

endmodule

`default_nettype wire

// ===== hdl/wbc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wbc_datapath #(
    parameter int MAX_TEXT  = 1024,
    parameter int MAX_WORDS = 256
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire wbc_pkg::item_t  item,
    input  wire logic            cfg_wr_en,
    input  wire logic [19:0]     cfg_wr_data,
    input  wire wbc_pkg::cmd_t   cmd,
    output wbc_pkg::sts_t        sts,
    output logic                 done,
    output wbc_pkg::result_t     result
);

    localparam int IW  = $clog2(MAX_TEXT + 1);
    localparam int LW  = $clog2(MAX_TEXT + 2);
    localparam int CW  = $clog2(MAX_WORDS + 1);
    localparam int DAW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int DW  = IW + 60;

    function automatic logic [29:0] add_small(input logic [29:0] x, input logic [5:0] v,
                                              input logic [29:0] m);
        logic [30:0] s;
        s = {1'b0, x} + {25'd0, v};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[29:0];
    endfunction

    function automatic logic [29:0] sub_mod(input logic [29:0] x, input logic [29:0] y,
                                            input logic [29:0] m);
        logic [30:0] s;
        if (x >= y)
            s = {1'b0, x} - {1'b0, y};
        else
            s = {1'b0, x} + {1'b0, m} - {1'b0, y};
        return s[29:0];
    endfunction

    logic [19:0]          base_reg;
    wbc_pkg::item_t       item_reg;
    logic [LW-1:0]        wlen_reg;
    logic [29:0]          wh1_reg, wh2_reg;
    logic [CW-1:0]        cnt_reg, w_reg;
    logic [IW-1:0]        n_reg, i_reg;
    logic                 ovf_reg;
    logic [29:0]          lp1_reg, lp2_reg, lw1_reg, lw2_reg;
    logic [29:0]          np1_reg, np2_reg, pi1_reg, pi2_reg, pe1_reg, pe2_reg;
    logic [29:0]          sp_reg, acc_reg;
    logic                 done_reg;
    wbc_pkg::result_t     res_reg;

    logic [DW-1:0]        dict_mem [MAX_WORDS];
    logic [DW-1:0]        dict_rd_reg;
    logic [59:0]          pre_mem [MAX_TEXT + 1];
    logic [59:0]          pre_rd_reg;
    logic [59:0]          pow_mem [MAX_TEXT + 1];
    logic [59:0]          pow_rd_reg;
    logic [29:0]          spl_mem [MAX_TEXT + 1];
    logic [29:0]          spl_rd_reg;

    logic [5:0]           val;
    logic [IW-1:0]        ent_len;
    logic [IW-1:0]        ent_end;
    logic [IW-1:0]        pre_addr;
    logic [IW-1:0]        spl_waddr;
    logic [29:0]          spl_wdata;
    logic [IW-1:0]        n_inc;
    logic [29:0]          ma1, ma2, mb1, mb2;
    logic                 md1, md2;
    logic [29:0]          prod1, prod2;
    logic [29:0]          chk1, chk2;
    logic [30:0]          acc_sum;
    logic [29:0]          acc_next;

    assign val       = {1'b0, item_reg.letter} + 6'd1;
    assign ent_len   = dict_rd_reg[DW-1:60];
    assign ent_end   = i_reg + ent_len;
    assign pre_addr  = cmd.row_rd ? i_reg : ent_end;
    assign spl_waddr = cmd.split_init ? n_reg : i_reg;
    assign spl_wdata = cmd.split_init ? 30'd1 : acc_reg;
    assign n_inc     = n_reg + IW'(1);
    assign chk1      = sub_mod(pe1_reg, prod1, wbc_pkg::MOD_ONE);
    assign chk2      = sub_mod(pe2_reg, prod2, wbc_pkg::MOD_TWO);
    assign acc_sum   = {1'b0, acc_reg} + {1'b0, sp_reg};
    assign acc_next  = (acc_sum >= {1'b0, wbc_pkg::MOD_ONE}) ?
                       30'(acc_sum - {1'b0, wbc_pkg::MOD_ONE}) : acc_sum[29:0];

    always_comb
    begin
        unique case (cmd.msel)
            wbc_pkg::MSEL_WORD:
            begin
                ma1 = wh1_reg;
                ma2 = wh2_reg;
                mb1 = {10'd0, base_reg};
                mb2 = {10'd0, base_reg};
            end
            wbc_pkg::MSEL_PREFIX:
            begin
                ma1 = lp1_reg;
                ma2 = lp2_reg;
                mb1 = {10'd0, base_reg};
                mb2 = {10'd0, base_reg};
            end
            wbc_pkg::MSEL_POWER:
            begin
                ma1 = lw1_reg;
                ma2 = lw2_reg;
                mb1 = {10'd0, base_reg};
                mb2 = {10'd0, base_reg};
            end
            wbc_pkg::MSEL_CHECK:
            begin
                ma1 = pi1_reg;
                ma2 = pi2_reg;
                mb1 = pow_rd_reg[59:30];
                mb2 = pow_rd_reg[29:0];
            end
            default:
            begin
                ma1 = '0;
                ma2 = '0;
                mb1 = '0;
                mb2 = '0;
            end
        endcase
    end

    wbc_mulmod u_mul_one (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (ma1),
        .b       (mb1),
        .modulus (wbc_pkg::MOD_ONE),
        .done    (md1),
        .product (prod1)
    );

    wbc_mulmod u_mul_two (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (ma2),
        .b       (mb2),
        .modulus (wbc_pkg::MOD_TWO),
        .done    (md2),
        .product (prod2)
    );

    // job state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= wbc_pkg::BASE_RESET;
            wlen_reg <= '0;
            wh1_reg  <= '0;
            wh2_reg  <= '0;
            cnt_reg  <= '0;
            w_reg    <= '0;
            n_reg    <= '0;
            i_reg    <= '0;
            ovf_reg  <= 1'b0;
            lp1_reg  <= '0;
            lp2_reg  <= '0;
            lw1_reg  <= 30'd1;
            lw2_reg  <= 30'd1;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cfg_wr_en)
                base_reg <= cfg_wr_data;
            if (cmd.word_upd)
            begin
                wh1_reg <= add_small(prod1, val, wbc_pkg::MOD_ONE);
                wh2_reg <= add_small(prod2, val, wbc_pkg::MOD_TWO);
                if (wlen_reg <= LW'(MAX_TEXT))
                    wlen_reg <= wlen_reg + LW'(1);
            end
            if (cmd.word_clr)
            begin
                wh1_reg  <= '0;
                wh2_reg  <= '0;
                wlen_reg <= '0;
            end
            if (cmd.w_clr || cmd.row_ld)
                w_reg <= '0;
            else if (cmd.w_inc)
                w_reg <= w_reg + CW'(1);
            if (cmd.dict_wr)
                cnt_reg <= cnt_reg + CW'(1);
            if (cmd.set_ovf)
                ovf_reg <= 1'b1;
            if (cmd.text_store)
            begin
                n_reg   <= n_inc;
                lp1_reg <= np1_reg;
                lp2_reg <= np2_reg;
                lw1_reg <= prod1;
                lw2_reg <= prod2;
            end
            if (cmd.split_init)
                i_reg <= n_reg - IW'(1);
            else if (cmd.i_dec)
                i_reg <= i_reg - IW'(1);
            if (cmd.finish)
            begin
                wh1_reg  <= '0;
                wh2_reg  <= '0;
                wlen_reg <= '0;
                cnt_reg  <= '0;
                n_reg    <= '0;
                ovf_reg  <= 1'b0;
                lp1_reg  <= '0;
                lp2_reg  <= '0;
                lw1_reg  <= 30'd1;
                lw2_reg  <= 30'd1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            item_reg <= item;
        if (cmd.pref_latch)
        begin
            np1_reg <= add_small(prod1, val, wbc_pkg::MOD_ONE);
            np2_reg <= add_small(prod2, val, wbc_pkg::MOD_TWO);
        end
        if (cmd.row_ld)
        begin
            pi1_reg <= sts.i_zero ? 30'd0 : pre_rd_reg[59:30];
            pi2_reg <= sts.i_zero ? 30'd0 : pre_rd_reg[29:0];
            acc_reg <= '0;
        end
        if (cmd.mul_start && cmd.msel == wbc_pkg::MSEL_CHECK)
        begin
            pe1_reg <= pre_rd_reg[59:30];
            pe2_reg <= pre_rd_reg[29:0];
            sp_reg  <= spl_rd_reg;
        end
        if (cmd.chk_done && chk1 == dict_rd_reg[59:30] && chk2 == dict_rd_reg[29:0])
            acc_reg <= acc_next;
        if (cmd.finish)
        begin
            res_reg.ways     <= sts.n_zero ? 30'd1 : acc_reg;
            res_reg.overflow <= ovf_reg;
        end
    end

    // dictionary store
    always_ff @(posedge clk)
    begin
        if (cmd.dict_wr)
            dict_mem[cnt_reg[DAW-1:0]] <= {wlen_reg[IW-1:0], wh1_reg, wh2_reg};
        if (cmd.dict_rd)
            dict_rd_reg <= dict_mem[w_reg[DAW-1:0]];
    end

    // prefix hash and power stores
    always_ff @(posedge clk)
    begin
        if (cmd.text_store)
        begin
            pre_mem[n_inc] <= {np1_reg, np2_reg};
            pow_mem[n_inc] <= {prod1, prod2};
        end
        if (cmd.row_rd || cmd.ent_ld)
            pre_rd_reg <= pre_mem[pre_addr];
        if (cmd.ent_ld)
            pow_rd_reg <= pow_mem[ent_len];
    end

    // split counts
    always_ff @(posedge clk)
    begin
        if (cmd.split_init || cmd.split_wr)
            spl_mem[spl_waddr] <= spl_wdata;
        if (cmd.ent_ld)
            spl_rd_reg <= spl_mem[ent_end];
    end

    always_comb
    begin
        sts.mul_done  = md1 & md2;
        sts.is_text   = (item_reg.opcode == wbc_pkg::OP_TEXT);
        sts.is_last   = item_reg.last;
        sts.text_full = (n_reg >= IW'(MAX_TEXT));
        sts.word_long = (wlen_reg > LW'(MAX_TEXT));
        sts.w_end     = (w_reg == cnt_reg);
        sts.dict_hit  = (dict_rd_reg == {wlen_reg[IW-1:0], wh1_reg, wh2_reg});
        sts.dict_full = (cnt_reg >= CW'(MAX_WORDS));
        sts.n_zero    = (n_reg == '0);
        sts.i_zero    = (i_reg == '0);
        sts.ent_skip  = (ent_len == '0) || (ent_len > (n_reg - i_reg));
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_dict_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_WORDS))
        else $error("dictionary count past capacity");

    a_text_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= IW'(MAX_TEXT))
        else $error("text length past capacity");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire

// ===== hdl/wbc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wbc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire wbc_pkg::sts_t  sts,
    output wbc_pkg::cmd_t       cmd,
    output logic                busy
);

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_LOAD     = 15'b000000000000010,
        S_WMUL     = 15'b000000000000100,
        S_WEND     = 15'b000000000001000,
        S_SRCH     = 15'b000000000010000,
        S_SRCH_CMP = 15'b000000000100000,
        S_TMUL_P   = 15'b000000001000000,
        S_TMUL_W   = 15'b000000010000000,
        S_CNT_INIT = 15'b000000100000000,
        S_ROW      = 15'b000001000000000,
        S_ROW_LD   = 15'b000010000000000,
        S_ENT      = 15'b000100000000000,
        S_ENT_LD   = 15'b001000000000000,
        S_ENT_MUL  = 15'b010000000000000,
        S_ENT_WAIT = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.msel   = wbc_pkg::MSEL_WORD;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (!sts.is_text)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_WMUL;
                end
                else if (sts.text_full)
                begin
                    cmd.set_ovf = 1'b1;
                    state_next  = sts.is_last ? S_CNT_INIT : S_IDLE;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.msel      = wbc_pkg::MSEL_PREFIX;
                    state_next    = S_TMUL_P;
                end
            end
            S_WMUL:
            begin
                if (sts.mul_done)
                begin
                    cmd.word_upd = 1'b1;
                    state_next   = sts.is_last ? S_WEND : S_IDLE;
                end
            end
            S_WEND:
            begin
                if (sts.word_long)
                begin
                    cmd.word_clr = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.w_clr  = 1'b1;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (sts.w_end)
                begin
                    cmd.dict_wr  = !sts.dict_full;
                    cmd.set_ovf  = sts.dict_full;
                    cmd.word_clr = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.dict_rd = 1'b1;
                    state_next  = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (sts.dict_hit)
                begin
                    cmd.word_clr = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.w_inc  = 1'b1;
                    state_next = S_SRCH;
                end
            end
            S_TMUL_P:
            begin
                if (sts.mul_done)
                begin
                    cmd.pref_latch = 1'b1;
                    cmd.mul_start  = 1'b1;
                    cmd.msel       = wbc_pkg::MSEL_POWER;
                    state_next     = S_TMUL_W;
                end
            end
            S_TMUL_W:
            begin
                if (sts.mul_done)
                begin
                    cmd.text_store = 1'b1;
                    state_next     = sts.is_last ? S_CNT_INIT : S_IDLE;
                end
            end
            S_CNT_INIT:
            begin
                if (sts.n_zero)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.split_init = 1'b1;
                    state_next     = S_ROW;
                end
            end
            S_ROW:
            begin
                cmd.row_rd = 1'b1;
                state_next = S_ROW_LD;
            end
            S_ROW_LD:
            begin
                cmd.row_ld = 1'b1;
                state_next = S_ENT;
            end
            S_ENT:
            begin
                if (sts.w_end)
                begin
                    cmd.split_wr = 1'b1;
                    if (sts.i_zero)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.i_dec  = 1'b1;
                        state_next = S_ROW;
                    end
                end
                else
                begin
                    cmd.dict_rd = 1'b1;
                    state_next  = S_ENT_LD;
                end
            end
            S_ENT_LD:
            begin
                if (sts.ent_skip)
                begin
                    cmd.w_inc  = 1'b1;
                    state_next = S_ENT;
                end
                else
                begin
                    cmd.ent_ld = 1'b1;
                    state_next = S_ENT_MUL;
                end
            end
            S_ENT_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.msel      = wbc_pkg::MSEL_CHECK;
                state_next    = S_ENT_WAIT;
            end
            S_ENT_WAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.chk_done = 1'b1;
                    cmd.w_inc    = 1'b1;
                    state_next   = S_ENT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/word_break_count_hashed.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Word-break counter with double polynomial hashing.
// Input channel: drive item with start; a transaction is taken on a rising edge with
// start high and busy low. Send dictionary letters (opcode 0) word by word, then text
// letters (opcode 1); last marks the end of a word or of the text.
// Result channel: done pulses for one cycle with result (ways, overflow) after the
// final text letter; the receiver cannot stall, so capture it on that edge.
// Configuration: cfg_wr_en writes hash_base; write it only while busy is low.
// Timing: every multiply runs through a bit-serial modular multiplier, one multiplier
// bit a cycle over 30 bits. busy stays high while a letter is worked on, so the next
// letter waits. A dictionary letter runs one multiply; a word's last letter adds the
// duplicate search over the stored words. A text letter runs two multiplies (prefix hash
// then power). The last text letter then runs the split count: for each of the n text
// positions, each stored word whose length fits is checked by a multiply (prefix times
// power), so the work grows with n times the number of stored words. done rises in the
// first cycle with busy low; the next transaction may be taken on the edge that ends
// it.
// Reset: hash_base returns to 131 and the dictionary, text and overflow flag clear.
// Each job clears itself after its result; hash_base keeps its value.
module word_break_count_hashed #(
    parameter int MAX_TEXT  = 1024,
    parameter int MAX_WORDS = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire wbc_pkg::item_t    item,
    output logic                   busy,
    output logic                   done,
    output wbc_pkg::result_t       result,
    input  wire logic              cfg_wr_en,
    input  wire logic [19:0]       cfg_wr_data
);

    wbc_pkg::cmd_t cmd;
    wbc_pkg::sts_t sts;

    // sequence letters, searches and the split walk
    wbc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // hold hashes, stores and the shared multipliers
    wbc_datapath #(
        .MAX_TEXT  (MAX_TEXT),
        .MAX_WORDS (MAX_WORDS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .done        (done),
        .result      (result)
    );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int TEXT_CAP  = 1024;
    localparam int WORD_CAP  = 256;
    localparam int WATCHDOG  = 2000000;

    logic             clk;
    logic             rst_n;
    logic             start;
    wbc_pkg::item_t   item;
    logic             busy;
    logic             done;
    wbc_pkg::result_t result;
    logic             cfg_wr_en;
    logic [19:0]      cfg_wr_data;

    word_break_count_hashed DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item), .busy(busy),
        .done(done), .result(result), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    // Predictor state: a shadow of the block's job.
    longint unsigned base_shadow;
    longint unsigned acc_one, acc_two;
    int              acc_len;
    longint unsigned dict_one[$], dict_two[$];
    int              dict_len[$];
    longint unsigned pre_one[$], pre_two[$], pow_one[$], pow_two[$];
    logic            ovf_shadow;

    wbc_pkg::result_t expected_ways[$];
    int               mismatches;
    int               idle_cycles;
    bit               timed_out;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Fold one letter into a rolling hash.
    function automatic longint unsigned roll(longint unsigned acc, longint unsigned mul,
                                             longint unsigned add, longint unsigned m);
        return ((acc * mul) % m + add) % m;
    endfunction

    function automatic void clear_job_shadow();
        acc_one = 0; acc_two = 0; acc_len = 0;
        dict_one.delete(); dict_two.delete(); dict_len.delete();
        pre_one = '{0}; pre_two = '{0}; pow_one = '{1}; pow_two = '{1};
        ovf_shadow = 1'b0;
    endfunction

    function automatic void file_word();
        bit seen;
        seen = 0;
        if (acc_len > TEXT_CAP)
            return;
        foreach (dict_len[w])
            if (dict_len[w] == acc_len && dict_one[w] == acc_one && dict_two[w] == acc_two)
                seen = 1;
        if (seen)
            return;
        if (dict_len.size() >= WORD_CAP)
        begin
            ovf_shadow = 1'b1;
            return;
        end
        dict_len = {dict_len, acc_len};
        dict_one = {dict_one, acc_one};
        dict_two = {dict_two, acc_two};
    endfunction

    // Walk the text backwards, summing the ways from each matching word.
    function automatic longint unsigned count_segmentations();
        int n;
        longint unsigned ways_at[];
        longint unsigned h1, h2, sum;
        int len;
        n = pre_one.size() - 1;
        ways_at = new[n + 1];
        ways_at[n] = 1;
        for (int i = n - 1; i >= 0; i--)
        begin
            sum = 0;
            foreach (dict_len[w])
            begin
                len = dict_len[w];
                if (len == 0 || len > n - i)
                    continue;
                h1 = (pre_one[i + len] + wbc_pkg::MOD_ONE -
                      (pre_one[i] * pow_one[len]) % wbc_pkg::MOD_ONE) % wbc_pkg::MOD_ONE;
                h2 = (pre_two[i + len] + wbc_pkg::MOD_TWO -
                      (pre_two[i] * pow_two[len]) % wbc_pkg::MOD_TWO) % wbc_pkg::MOD_TWO;
                if (h1 == dict_one[w] && h2 == dict_two[w])
                    sum = (sum + ways_at[i + len]) % wbc_pkg::MOD_ONE;
            end
            ways_at[i] = sum;
        end
        return ways_at[0];
    endfunction

    function automatic void predict_letter(wbc_pkg::item_t it);
        longint unsigned v;
        int n;
        wbc_pkg::result_t r;
        v = longint'(it.letter) + 1;
        if (it.opcode == wbc_pkg::OP_WORD)
        begin
            if (acc_len <= TEXT_CAP)
                acc_len++;
            acc_one = roll(acc_one, base_shadow, v, wbc_pkg::MOD_ONE);
            acc_two = roll(acc_two, base_shadow, v, wbc_pkg::MOD_TWO);
            if (it.last)
            begin
                file_word();
                acc_one = 0; acc_two = 0; acc_len = 0;
            end
            return;
        end
        n = pre_one.size() - 1;
        if (n < TEXT_CAP)
        begin
            pre_one = {pre_one, roll(pre_one[n], base_shadow, v, wbc_pkg::MOD_ONE)};
            pre_two = {pre_two, roll(pre_two[n], base_shadow, v, wbc_pkg::MOD_TWO)};
            pow_one = {pow_one, roll(pow_one[n], base_shadow, 0, wbc_pkg::MOD_ONE)};
            pow_two = {pow_two, roll(pow_two[n], base_shadow, 0, wbc_pkg::MOD_TWO)};
        end
        else
            ovf_shadow = 1'b1;
        if (!it.last)
            return;
        r.ways = 30'(count_segmentations());
        r.overflow = ovf_shadow;
        expected_ways = {expected_ways, r};
        clear_job_shadow();
    endfunction

    // Send one letter; hold start until the block takes the transaction.
    task automatic send_letter(logic op, logic [4:0] ltr, logic lst);
        wbc_pkg::item_t it;
        it.opcode = op; it.letter = ltr; it.last = lst;
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        predict_letter(it);
        // Drop start only when a gap follows, so no step sees two assignments.
        if ($urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_word(logic op, logic [4:0] ltrs[$]);
        foreach (ltrs[k])
            send_letter(op, ltrs[k], k == ltrs.size() - 1);
    endtask

    // Idle start, let the block drain, then write the base.
    task automatic write_base(logic [19:0] b);
        start <= 1'b0;
        while (expected_ways.size() != 0)
            @(posedge clk);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= b;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        base_shadow = b;
    endtask

    // Check each result strobe against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_ways.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result ways=%0d overflow=%0b",
                             result.ways, result.overflow);
            end
            else
            begin
                if (result !== expected_ways[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected ways=%0d ovf=%0b, got ways=%0d ovf=%0b",
                                 expected_ways[0].ways, expected_ways[0].overflow,
                                 result.ways, result.overflow);
                end
                void'(expected_ways.pop_front());
            end
        end
    end

    // Watchdog: count cycles in which nothing is accepted and no result appears.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [4:0] rand_letter(int alpha);
        return 5'($urandom_range(0, alpha - 1));
    endfunction

    // Extremes: empty-like one-letter text, letters 0, 25, 31, duplicate words.
    task automatic test_directed();
        send_word(wbc_pkg::OP_WORD, '{5'd0});
        send_word(wbc_pkg::OP_WORD, '{5'd0, 5'd0});
        send_word(wbc_pkg::OP_WORD, '{5'd0});
        send_word(wbc_pkg::OP_WORD, '{5'd25, 5'd31});
        send_word(wbc_pkg::OP_TEXT, '{5'd0, 5'd0, 5'd0, 5'd25, 5'd31});
        // Text with no dictionary at all.
        send_word(wbc_pkg::OP_TEXT, '{5'd7});
        // Unfinished word discarded when the job ends.
        send_letter(wbc_pkg::OP_WORD, 5'd3, 1'b0);
        send_word(wbc_pkg::OP_TEXT, '{5'd3, 5'd3});
        send_word(wbc_pkg::OP_WORD, '{5'd31, 5'd16, 5'd8});
        send_word(wbc_pkg::OP_TEXT, '{5'd31, 5'd16, 5'd8});
    endtask

    // Small alphabet so that words really split the text.
    task automatic test_random_jobs(int jobs);
        logic [4:0] w[$];
        int alpha;
        repeat (jobs)
        begin
            alpha = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(1, 3);
            repeat ($urandom_range(0, 6))
            begin
                w.delete();
                repeat ($urandom_range(1, 3)) w = {w, rand_letter(alpha)};
                send_word(wbc_pkg::OP_WORD, w);
            end
            w.delete();
            repeat ($urandom_range(1, 8)) w = {w, rand_letter(alpha)};
            send_word(wbc_pkg::OP_TEXT, w);
        end
    endtask

    // Fill the dictionary past capacity: all single letters, then two-letter words.
    task automatic test_dictionary_overflow();
        for (int k = 0; k < WORD_CAP + 2; k++)
        begin
            if (k < 32)
                send_word(wbc_pkg::OP_WORD, '{5'(k)});
            else
                send_word(wbc_pkg::OP_WORD, '{5'((k - 32) / 32), 5'((k - 32) % 32)});
        end
        send_word(wbc_pkg::OP_TEXT, '{5'd0, 5'd1});
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        base_shadow = wbc_pkg::BASE_RESET;
        clear_job_shadow();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_base(20'd50);
        test_random_jobs(5);
        write_base(20'd1000000);
        test_random_jobs(5);
        write_base(20'($urandom_range(50, 1000000)));
        test_dictionary_overflow();
        write_base(20'd131);
        test_random_jobs(3);
        write_base(20'hFFFFF);
        test_random_jobs(2);
        write_base(20'($urandom_range(50, 1000000)));
        test_random_jobs(4);

        start <= 1'b0;
        while (expected_ways.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
